// ===== rtl/pso_pkg.sv =====
// Package for the pulse oscillator: fixed-point formats, register indexes and
// phase, ramp and reciprocal constants. No dependencies.
package pso_pkg;

  // Fixed-point formats
  localparam int unsigned PhaseFracBits = 24;
  localparam int unsigned OutFracBits   = 15;
  localparam int unsigned PhaseW        = PhaseFracBits + 3;
  localparam int unsigned FreqW         = 24;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned DutyW         = 10;
  localparam int unsigned DutyShift     = PhaseFracBits - DutyW;
  localparam int unsigned OutShift      = PhaseFracBits - OutFracBits;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CfgRateSelect = 1'b0,
    CfgDuty       = 1'b1
  } cfg_idx_e;

  localparam logic [DutyW-1:0] DutyMin   = 10'd51;
  localparam logic [DutyW-1:0] DutyMax   = 10'd973;
  localparam logic [DutyW-1:0] DutyReset = 10'd512;

  // Phase constants: one cycle is 1.0, the edge ramps are 0.01 wide
  localparam longint unsigned OneVal  = 64'd1 << PhaseFracBits;
  localparam longint unsigned EdgeVal = (OneVal + 64'd50) / 64'd100;
  localparam logic signed [PhaseW-1:0] PhaseOne  = PhaseW'(OneVal);
  localparam logic signed [PhaseW-1:0] PhaseEdge = PhaseW'(EdgeVal);

  // Ramp offset width: holds any value below the edge
  localparam int unsigned RampW     = $clog2(EdgeVal + 64'd1);
  localparam int unsigned SlopeW    = 8;
  localparam logic [SlopeW-1:0] RampSlope = 8'd140;
  localparam int unsigned RampProdW = RampW + SlopeW;
  // Signed working width for ramp values before saturation
  localparam int unsigned WaveW     = RampProdW - OutShift + 2;

  // Amplitude 0.7 in the output format
  localparam longint unsigned AmpVal = ((64'd7 << OutFracBits) + 64'd5) / 64'd10;
  localparam logic signed [SampleW-1:0] Amp = SampleW'(AmpVal);

  // Reciprocals round(2^48/rate); product split into low and high partial products
  localparam int unsigned RecipW    = 33;
  localparam int unsigned RecipLoW  = 17;
  localparam int unsigned RecipHiW  = RecipW - RecipLoW;
  localparam logic [RecipW-1:0] Recip44k = 33'd6382652533;
  localparam logic [RecipW-1:0] Recip48k = 33'd5864062015;
  localparam int unsigned IncShift  = 56 - PhaseFracBits;
  localparam int unsigned ProdW     = FreqW + RecipW;
  localparam int unsigned PpLoW     = FreqW + RecipLoW;
  localparam int unsigned PpHiW     = FreqW + RecipHiW;
  localparam int unsigned IncMagW   = PhaseFracBits;

endpackage

// ===== rtl/pso_if.sv =====
// Valid/ready channel interfaces for the pulse oscillator's input and result
// streams. Depends on pso_pkg.
interface pso_in_if import pso_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [FreqW-1:0] freq;

  modport source (output valid, action, freq, input ready);
  modport sink   (input valid, action, freq, output ready);
endinterface

interface pso_out_if import pso_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      cycle_restart;

  modport source (output valid, sample, cycle_restart, input ready);
  modport sink   (input valid, sample, cycle_restart, output ready);
endinterface

// ===== rtl/pwm_square_oscillator.sv =====
// Pulse oscillator with a signed phase accumulator and edge-ramped output.
// Depends on pso_pkg and the channel interfaces in pso_if.sv.
//
// The block takes one transaction per clock unless a stalled result has filled
// the pipeline. Each returns its sample after the input register, two stages that
// form the phase increment from freq times a rate reciprocal as two partial
// products, then the phase accumulator stage, which closes its loop and loads the
// result register. A sync transaction zeroes the phase and produces no result.
// Stages hold on a stalled result only where they are occupied, so bubbles close
// up and input stays open while a result waits until the pipeline fills. Write
// configuration only when the pipeline is empty; a duty write clears the phase.
module pwm_square_oscillator import pso_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DutyW-1:0]   cfg_wdata_i,
  pso_in_if.sink             in_i,
  pso_out_if.source          out_o
);

  // Configuration
  logic             rate_sel_q;
  logic [DutyW-1:0] duty_q;
  logic [DutyW-1:0] duty_d;
  logic             duty_we;

  // Pipeline
  logic                       s1_v_q, s1_sync_q;
  logic signed [FreqW-1:0]    s1_freq_q;
  logic                       s2_v_q, s2_sync_q, s2_neg_q;
  logic [PpLoW-1:0]           s2_pp_lo_q;
  logic [PpHiW-1:0]           s2_pp_hi_q;
  logic                       s3_v_q, s3_sync_q;
  logic signed [IncMagW:0]    s3_inc_q;
  logic                       out_v_q;
  logic signed [SampleW-1:0]  sample_q;
  logic                       restart_q;
  logic signed [PhaseW-1:0]   phase_q;

  logic s1_en, s2_en, s3_en, out_en;

  // Stage 2 / 3 combinational
  logic                  s1_neg;
  logic [FreqW-1:0]      s1_mag;
  logic [RecipW-1:0]     recip;
  logic [PpLoW-1:0]      pp_lo_d;
  logic [PpHiW-1:0]      pp_hi_d;
  logic [ProdW-1:0]      prod_sum;
  logic [IncMagW-1:0]    inc_mag;
  logic signed [IncMagW:0] inc_d;

  // Phase stage combinational
  logic                      wrap;
  logic signed [PhaseW-1:0]  p_fold;
  logic signed [PhaseW-1:0]  dpos;
  logic signed [PhaseW-1:0]  p_off;
  logic                      in_rise, in_high, in_fall;
  logic [RampW-1:0]          ramp_t;
  logic [RampProdW-1:0]      ramp_prod;
  logic signed [WaveW-1:0]   ramp_scaled;
  logic signed [WaveW-1:0]   wave_raw;
  logic signed [SampleW-1:0] sample_d;

  // ---------------------------------------------------------------------------
  // Configuration registers

  always_comb begin
    duty_d = cfg_wdata_i;
    if (cfg_wdata_i < DutyMin) begin
      duty_d = DutyMin;
    end else if (cfg_wdata_i > DutyMax) begin
      duty_d = DutyMax;
    end
  end

  assign duty_we = cfg_we_i && (cfg_idx_i == CfgDuty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_sel_q <= 1'b0;
      duty_q     <= DutyReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRateSelect: rate_sel_q <= cfg_wdata_i[0];
        CfgDuty:       duty_q     <= duty_d;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage advances when empty or when its successor advances; a sync in stage 3 always advances

  assign out_en     = !out_v_q || out_o.ready;
  assign s3_en      = !s3_v_q || s3_sync_q || out_en;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_i.ready = s1_en;

  // ---------------------------------------------------------------------------
  // Stage 1: input register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_i.valid) begin
      s1_sync_q <= in_i.action;
      s1_freq_q <= in_i.freq;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitude times reciprocal, as two partial products

  assign s1_neg  = s1_freq_q[FreqW-1];
  assign s1_mag  = s1_neg ? (~s1_freq_q + FreqW'(1)) : s1_freq_q;
  assign recip   = rate_sel_q ? Recip48k : Recip44k;
  assign pp_lo_d = PpLoW'(s1_mag) * PpLoW'(recip[RecipLoW-1:0]);
  assign pp_hi_d = PpHiW'(s1_mag) * PpHiW'(recip[RecipW-1:RecipLoW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      s2_sync_q  <= s1_sync_q;
      s2_neg_q   <= s1_neg;
      s2_pp_lo_q <= pp_lo_d;
      s2_pp_hi_q <= pp_hi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine partial products, round and apply the sign

  assign prod_sum = {s2_pp_hi_q, {RecipLoW{1'b0}}} + ProdW'(s2_pp_lo_q)
                  + (ProdW'(1) << (IncShift - 1));
  assign inc_mag  = prod_sum[IncShift +: IncMagW];
  assign inc_d    = s2_neg_q ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      s3_sync_q <= s2_sync_q;
      s3_inc_q  <= inc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: fold phase, shape waveform, advance phase

  always_comb begin
    wrap   = 1'b0;
    p_fold = phase_q;
    if (phase_q > PhaseOne) begin
      p_fold = phase_q - PhaseOne;
      wrap   = 1'b1;
    end else if (phase_q < 0) begin
      p_fold = phase_q + PhaseOne;
    end
  end

  assign dpos    = $signed(PhaseW'({duty_q, {DutyShift{1'b0}}}));
  assign p_off   = p_fold - dpos;
  assign in_rise = p_fold < PhaseEdge;
  assign in_high = p_fold < dpos;
  assign in_fall = p_fold < (dpos + PhaseEdge);

  // Rising ramp treats a still-negative phase as zero
  always_comb begin
    if (in_rise) begin
      ramp_t = (p_fold > 0) ? p_fold[RampW-1:0] : '0;
    end else begin
      ramp_t = p_off[RampW-1:0];
    end
  end

  assign ramp_prod   = RampProdW'(ramp_t) * RampProdW'(RampSlope);
  assign ramp_scaled = $signed(WaveW'(ramp_prod >> OutShift));

  always_comb begin
    wave_raw = -WaveW'(Amp);
    if (in_rise) begin
      wave_raw = -WaveW'(Amp) + ramp_scaled;
    end else if (in_high) begin
      wave_raw = WaveW'(Amp);
    end else if (in_fall) begin
      wave_raw = WaveW'(Amp) - ramp_scaled;
    end
    // saturate to +-0.7
    if (wave_raw > WaveW'(Amp)) begin
      sample_d = Amp;
    end else if (wave_raw < -WaveW'(Amp)) begin
      sample_d = -Amp;
    end else begin
      sample_d = SampleW'(wave_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (duty_we) begin
      phase_q <= '0;
    end else if (s3_v_q && s3_en) begin
      if (s3_sync_q) begin
        phase_q <= '0;
      end else begin
        // wrap in the accumulator width
        phase_q <= p_fold + PhaseW'(s3_inc_q);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s3_v_q && !s3_sync_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s3_v_q && !s3_sync_q) begin
      sample_q  <= sample_d;
      restart_q <= wrap;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.sample        = sample_q;
  assign out_o.cycle_restart = restart_q;

  // ---------------------------------------------------------------------------
  // Assertions

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.sample <= Amp) && (out_o.sample >= -Amp))
    else $error("sample outside +-0.7");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q >= DutyMin) && (duty_q <= DutyMax))
    else $error("duty register out of clamp range");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> in_i.ready)
    else $error("empty input stage refuses a transaction");

  a_sync_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_sync_q && out_en && !duty_we) |=> (phase_q == '0))
    else $error("sync did not clear the phase");

endmodule

// ===== sim/tb_pwm_square_oscillator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pwm_square_oscillator: random and directed
// transactions with a cycle-free phase accumulator predictor. Needs pso_pkg and pso_if.sv.
module tb_pwm_square_oscillator import pso_pkg::*; ();

  localparam int FreqHi  = 6144000;
  localparam int HoldLen = 80;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } pulse_t;

  // Tracks phase and registers, holds the samples still owed by the block
  class pulse_tracker;
    logic signed [PhaseW-1:0] phase_acc;
    logic                     rate_sel;
    logic [DutyW-1:0]         duty_reg;
    pulse_t                   expected_pulses[$];
    int                       fail_count;

    function new();
      phase_acc  = '0;
      rate_sel   = 1'b0;
      duty_reg   = DutyReset;
      fail_count = 0;
    endfunction

    task report_mismatch(string msg);
      if (fail_count < 30) $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    function int pending();
      return expected_pulses.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [DutyW-1:0] data);
      case (idx)
        CfgRateSelect: rate_sel = data[0];
        CfgDuty: begin
          if (data < DutyMin) duty_reg = DutyMin;
          else if (data > DutyMax) duty_reg = DutyMax;
          else duty_reg = data;
          phase_acc = '0;
        end
        default: ;
      endcase
    endfunction

    function logic signed [SampleW-1:0] wave_at(longint p);
      longint edge_len, amp_l, dpos, slope, v;
      edge_len = longint'(EdgeVal);
      amp_l    = longint'(AmpVal);
      slope    = longint'(RampSlope);
      dpos     = longint'(duty_reg) << DutyShift;
      if (p < edge_len) v = -amp_l + ((((p > 0) ? p : 0) * slope) >>> OutShift);
      else if (p < dpos) v = amp_l;
      else if (p < dpos + edge_len) v = amp_l - (((p - dpos) * slope) >>> OutShift);
      else v = -amp_l;
      if (v > amp_l) v = amp_l;
      if (v < -amp_l) v = -amp_l;
      return SampleW'(v);
    endfunction

    // freq * 65536 / rate via the rounded reciprocal, sign applied to the magnitude
    function longint phase_step(logic signed [FreqW-1:0] f);
      longint unsigned mag, recip, inc;
      recip = rate_sel ? Recip48k : Recip44k;
      if (f < 0) mag = -longint'(f);
      else mag = longint'(f);
      inc = (mag * recip + (64'd1 << (IncShift - 1))) >> IncShift;
      return (f < 0) ? -longint'(inc) : longint'(inc);
    endfunction

    function void take_input(logic action, logic signed [FreqW-1:0] f);
      longint p, one_l;
      pulse_t r;
      if (action) begin
        phase_acc = '0;
        return;
      end
      one_l     = longint'(OneVal);
      p         = phase_acc;
      r.restart = 1'b0;
      // fold back into one cycle; exactly 1.0 stays put
      if (p > one_l) begin
        p = p - one_l;
        r.restart = 1'b1;
      end else if (p < 0) begin
        p = p + one_l;
      end
      r.sample = wave_at(p);
      expected_pulses.push_back(r);
      phase_acc = PhaseW'(p + phase_step(f));
    endfunction

    task check_sample(logic signed [SampleW-1:0] s, logic rs);
      pulse_t want;
      if (expected_pulses.size() == 0) begin
        report_mismatch($sformatf("sample %0d with none outstanding", s));
        return;
      end
      want = expected_pulses.pop_front();
      if (s !== want.sample)
        report_mismatch($sformatf("sample %0d, predicted %0d", s, want.sample));
      if (rs !== want.restart)
        report_mismatch($sformatf("cycle_restart %0b, predicted %0b", rs, want.restart));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [DutyW-1:0] cfg_wdata;
  int hold_req  = 0;
  int hold_done = 0;

  pulse_tracker board = new();

  pso_in_if  in_ch ();
  pso_out_if out_ch ();

  pwm_square_oscillator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_sample(out_ch.sample, out_ch.cycle_restart);
  end

  // Result side: short stalls, long open runs, and a long hold-off on request
  initial begin : result_sink
    int run_left, stall_left, hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_done != hold_req) begin
        hold_left = HoldLen;
        hold_done = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (run_left > 0) run_left--;
        else if ($urandom_range(3) == 0) run_left = $urandom_range(20, 60);
        else begin
          run_left   = $urandom_range(0, 5);
          stall_left = $urandom_range(1, 4);
        end
      end
    end
  end

  task automatic send_item(input logic act, input logic signed [FreqW-1:0] f);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.freq   <= f;
    do @(posedge clk); while (!in_ch.ready);
    board.take_input(act, f);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DutyW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Wait out outstanding samples, then let a trailing sync drain
  task automatic settle();
    for (int k = 0; k < 4000 && board.pending() > 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_freq(int mode);
    case (mode)
      0: return int'($urandom_range(2 * FreqHi)) - FreqHi;
      1: return int'($urandom_range(40000)) - 20000;
      default: begin
        case ($urandom_range(3))
          0: return FreqHi;
          1: return -FreqHi;
          2: return 5644800;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // Bursts at a held tone, mostly; some bursts change freq every transaction
  task automatic play_random(input int count, input bit dense);
    int sent, burst, gap, mode, tone;
    logic act;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      mode  = $urandom_range(3);
      tone  = pick_freq(mode);
      if ($urandom_range(3) == 0) begin
        send_item(1'b1, FreqW'($urandom));
        sent++;
      end
      for (int k = 0; k < burst && sent < count; k++) begin
        act = ($urandom_range(49) == 0);
        if (mode == 3) tone = pick_freq($urandom_range(2));
        send_item(act, FreqW'(tone));
        sent++;
      end
      gap = (dense || $urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int rate_plan [8];
    int duty_plan [8];
    logic [DutyW-1:0] duty_word;
    rate_plan = '{1, 0, 1, 0, 1, 0, 1, 0};
    duty_plan = '{0, 1023, 51, 973, 50, 974, -1, -1};
    in_ch.valid  <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.freq   <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CfgRateSelect;
    cfg_wdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CfgRateSelect, 10'h3FE);
    write_reg(CfgDuty, DutyReset);
    // 5644800 steps exactly half a cycle at 44.1 kHz: land on duty, then on 1.0, then wrap
    repeat (4) send_item(1'b0, 24'sd5644800);
    send_item(1'b1, 24'sd123);
    repeat (3) send_item(1'b0, 24'sd11025);
    send_item(1'b0, '0);
    repeat (3) send_item(1'b0, -24'sd6144000);
    send_item(1'b1, -24'sd1);
    repeat (2) send_item(1'b0, 24'sd6144000);
    send_item(1'b0, 24'sd1);
    send_item(1'b0, -24'sd1);
    send_item(1'b0, 24'sh555555);
    send_item(1'b0, 24'shAAAAAA);
    in_ch.valid <= 1'b0;
    settle();

    for (int i = 0; i < 8; i++) begin
      duty_word = (duty_plan[i] < 0) ? DutyW'($urandom_range(1023)) : DutyW'(duty_plan[i]);
      write_reg(CfgRateSelect, {(DutyW - 1)'($urandom), rate_plan[i][0]});
      write_reg(CfgDuty, duty_word);
      // stall the result side hard while input keeps coming
      if (i == 2) hold_req++;
      play_random(200, i == 2);
      settle();
    end

    if (board.pending() > 0)
      board.report_mismatch($sformatf("%0d samples never arrived", board.pending()));
    if (board.fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
